### hw/rtl/segment_lcd_mux_driver_assert.svh
// Assertion macros used by the checker of the segment LCD driver.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef SEGMENT_LCD_MUX_DRIVER_ASSERT_SVH
`define SEGMENT_LCD_MUX_DRIVER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLMD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment LCD driver assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SLMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment LCD driver assertion failed");

`endif

### hw/rtl/slmd_pkg.sv
// Package of the segment LCD driver: action codes, pattern type and the
// seven-segment table. No dependencies.
`default_nettype none

package slmd_pkg;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SET_MIN = 2'd1;
    localparam logic [1:0] ACT_SET_SEC = 2'd2;

    localparam logic [6:0] VALUE_MAX = 7'd99;

    typedef logic [3:0][7:0] t_pattern;

    localparam t_pattern PATTERN_RESET = {8'h04, 8'h00, 8'h00, 8'h00};

    // Segment code of a decimal digit, bit 0 = a through bit 6 = g.
    function automatic logic [6:0] seven_seg(input logic [3:0] digit);
        logic [6:0] code;
        case (digit)
            4'd0: code = 7'h3f;
            4'd1: code = 7'h06;
            4'd2: code = 7'h5b;
            4'd3: code = 7'h4f;
            4'd4: code = 7'h66;
            4'd5: code = 7'h6d;
            4'd6: code = 7'h7d;
            4'd7: code = 7'h07;
            4'd8: code = 7'h7f;
            4'd9: code = 7'h6f;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/slmd_pattern_upd.sv
// Next value of the four common patterns for one item; only set items change them.
// Depends on slmd_pkg for the pattern type, action codes and segment table.
`default_nettype none

module slmd_pattern_upd (
    input  wire slmd_pkg::t_pattern i_pattern,
    input  wire logic [1:0]         i_action,
    input  wire logic [6:0]         i_value,
    input  wire logic [1:0]         i_battery_level,
    input  wire logic               i_blink_off,
    output slmd_pkg::t_pattern      o_pattern
);

    logic [6:0]  value_c;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [6:0]  code_t;
    logic [6:0]  code_o;
    logic [3:0]  t_hi;
    logic [3:0]  t_lo;
    logic [3:0]  o_hi;
    logic [3:0]  o_lo;

    assign value_c   = (i_value > slmd_pkg::VALUE_MAX) ? slmd_pkg::VALUE_MAX : i_value;
    // Multiplying by 205 and dropping 11 bits divides by ten for values up to 99.
    assign tens_prod = 15'(value_c) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = 4'(value_c - 7'(tens) * 7'd10);
    assign code_t    = slmd_pkg::seven_seg(tens);
    assign code_o    = slmd_pkg::seven_seg(ones);

    assign t_hi = {code_t[3], code_t[4], code_t[6], code_t[5]};
    assign t_lo = {1'b0, code_t[2], code_t[1], code_t[0]};
    assign o_hi = {code_o[3], code_o[4], code_o[6], code_o[5]};
    assign o_lo = {1'b0, code_o[2], code_o[1], code_o[0]};

    always_comb begin
        o_pattern = i_pattern;
        if (!i_blink_off) begin
            case (i_action)
                slmd_pkg::ACT_SET_MIN: begin
                    for (int c = 0; c < 4; c++) begin
                        o_pattern[c][7] = t_hi[c];
                        o_pattern[c][6] = t_lo[c];
                        o_pattern[c][5] = o_hi[c];
                        o_pattern[c][4] = o_lo[c];
                    end
                    o_pattern[3][6] = (i_battery_level == 2'd3);
                    o_pattern[3][4] = i_battery_level[1];
                end
                slmd_pkg::ACT_SET_SEC: begin
                    for (int c = 0; c < 4; c++) begin
                        o_pattern[c][3] = t_hi[c];
                        o_pattern[c][2] = t_lo[c];
                        o_pattern[c][0] = o_hi[c];
                        o_pattern[c][1] = o_lo[c];
                    end
                    o_pattern[3][2] = 1'b1;
                    o_pattern[3][1] = |i_battery_level;
                end
                default: begin
                    o_pattern = i_pattern;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/segment_lcd_mux_driver.sv
// Top level of the four-common segment LCD driver.
// Depends on slmd_pkg and slmd_pattern_upd.
//
// Input channel: i_valid / o_stall with i_action, i_value, i_battery_level
// and i_blink_off. A set-minutes or set-seconds transfer rewrites the common
// patterns (not with i_blink_off) and gives no result. A scan tick gives one
// result on the output channel o_valid / i_stall: o_seg_drive, o_com_index and
// o_com_level for the current of eight scan phases; the phase then advances.
// Every transfer lands in an input register. From there a set item rewrites
// the patterns, while a tick's result moves into the result register once
// that is free and shows on the output channel. One transfer per cycle
// is taken as long as the receiver keeps up. While a result waits under
// i_stall, set items still pass; a tick waits in the input register, and
// o_stall rises only then.
// Reset (i_rst_n low at a clock edge) clears the scan phase to zero, clears
// the patterns except the always-on S4 icon, and empties both registers.
`default_nettype none

module segment_lcd_mux_driver (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [6:0] i_value,
    input  wire logic [1:0] i_battery_level,
    input  wire logic       i_blink_off,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_seg_drive,
    output logic [1:0]      o_com_index,
    output logic            o_com_level
);

    logic               r_in_valid;
    logic [1:0]         r_in_action;
    logic [6:0]         r_in_value;
    logic [1:0]         r_in_level;
    logic               r_in_blink;
    slmd_pkg::t_pattern r_pattern;
    slmd_pkg::t_pattern n_pattern;
    logic [2:0]         r_scan_phase;
    logic               r_out_valid;
    logic [7:0]         r_seg_drive;
    logic [1:0]         r_com_index;
    logic               r_com_level;

    logic       is_tick;
    logic       out_free;
    logic       proc;
    logic [7:0] cur_pat;

    assign is_tick  = (r_in_action == slmd_pkg::ACT_TICK);
    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && (!is_tick || out_free);
    assign o_stall  = r_in_valid && !proc;
    assign cur_pat  = r_pattern[r_scan_phase[2:1]];

    slmd_pattern_upd u_upd (
        .i_pattern       (r_pattern),
        .i_action        (r_in_action),
        .i_value         (r_in_value),
        .i_battery_level (r_in_level),
        .i_blink_off     (r_in_blink),
        .o_pattern       (n_pattern)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pattern    <= slmd_pkg::PATTERN_RESET;
            r_scan_phase <= 3'd0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= proc && is_tick;
            end
            if (proc) begin
                r_pattern <= n_pattern;
            end
            if (proc && is_tick) begin
                r_scan_phase <= r_scan_phase + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_action <= i_action;
            r_in_value  <= i_value;
            r_in_level  <= i_battery_level;
            r_in_blink  <= i_blink_off;
        end
        if (proc && is_tick) begin
            r_seg_drive <= r_scan_phase[0] ? cur_pat : ~cur_pat;
            r_com_index <= r_scan_phase[2:1];
            r_com_level <= !r_scan_phase[0];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_seg_drive = r_seg_drive;
    assign o_com_index = r_com_index;
    assign o_com_level = r_com_level;

endmodule

`default_nettype wire

### hw/rtl/slmd_checker.sv
// Port-level checker of the segment LCD driver and its bind to the top level.
// Depends on segment_lcd_mux_driver_assert.svh.
`default_nettype none
`include "segment_lcd_mux_driver_assert.svh"

module slmd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_seg_drive,
    input wire logic [1:0] o_com_index,
    input wire logic       o_com_level
);

    logic [2:0] r_exp_phase;
    logic       out_xfer;

    assign out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_phase <= 3'd0;
        end else if (out_xfer) begin
            r_exp_phase <= r_exp_phase + 3'd1;
        end
    end

    `SLMD_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_seg_drive))
    `SLMD_ASSERT_NOW(a_phase_order, out_xfer, {o_com_index, !o_com_level} == r_exp_phase)
    `SLMD_ASSERT_NOW(a_s4_on, o_valid && o_com_index == 2'd3, o_seg_drive[2] != o_com_level)
    `SLMD_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall)

endmodule

bind segment_lcd_mux_driver slmd_checker u_slmd_checker (.*);

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench of the four-common segment LCD driver.
// Depends on slmd_pkg and segment_lcd_mux_driver; a scoreboard class predicts each scan
// result from the accepted transfers and checks the output channel against it.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 650;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] seg_drive;
        logic [1:0] com_index;
        logic       com_level;
    } t_lcd_scan;

    class t_lcd_scoreboard;
        logic [7:0] com_pat [4];
        logic [2:0] phase;
        logic [6:0] seg_table [10];
        t_lcd_scan  scan_q [$];
        int         errors;

        function new();
            seg_table = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f};
            com_pat   = '{8'h00, 8'h00, 8'h00, 8'h04};
            phase     = 3'd0;
            errors    = 0;
        endfunction

        function void place_digit(logic [6:0] code, int hi, int lo, logic [7:0] keep);
            com_pat[0] = (com_pat[0] & keep) | ({7'b0, code[5]} << hi) | ({7'b0, code[0]} << lo);
            com_pat[1] = (com_pat[1] & keep) | ({7'b0, code[6]} << hi) | ({7'b0, code[1]} << lo);
            com_pat[2] = (com_pat[2] & keep) | ({7'b0, code[4]} << hi) | ({7'b0, code[2]} << lo);
            com_pat[3] = (com_pat[3] & keep) | ({7'b0, code[3]} << hi);
        endfunction

        function void note_input(logic [1:0] act, logic [6:0] val, logic [1:0] lvl,
                                 logic blink);
            t_lcd_scan  scan;
            logic [7:0] pat;
            int         clamped;
            if (act == slmd_pkg::ACT_TICK) begin
                pat            = com_pat[phase[2:1]];
                scan.seg_drive = phase[0] ? pat : ~pat;
                scan.com_index = phase[2:1];
                scan.com_level = ~phase[0];
                scan_q.push_back(scan);
                phase = phase + 3'd1;
            end else if ((act == slmd_pkg::ACT_SET_MIN || act == slmd_pkg::ACT_SET_SEC)
                         && !blink) begin
                clamped = (val > slmd_pkg::VALUE_MAX) ? slmd_pkg::VALUE_MAX : val;
                if (act == slmd_pkg::ACT_SET_MIN) begin
                    place_digit(seg_table[clamped / 10], 7, 6, 8'h3F);
                    if (lvl == 2'd3) com_pat[3] |= 8'h40;
                    place_digit(seg_table[clamped % 10], 5, 4, 8'hCF);
                    if (lvl >= 2'd2) com_pat[3] |= 8'h10;
                end else begin
                    place_digit(seg_table[clamped / 10], 3, 2, 8'hF3);
                    com_pat[3] |= 8'h04;
                    place_digit(seg_table[clamped % 10], 0, 1, 8'hFC);
                    if (lvl >= 2'd1) com_pat[3] |= 8'h02;
                end
            end
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [7:0] seg, logic [1:0] idx, logic lvl);
            t_lcd_scan want;
            if (scan_q.size() == 0) begin
                report($sformatf("unexpected result seg=%02h com=%0d level=%0b", seg, idx, lvl));
            end else begin
                want = scan_q.pop_front();
                if (seg !== want.seg_drive)
                    report($sformatf("seg_drive %02h, expected %02h", seg, want.seg_drive));
                if (idx !== want.com_index)
                    report($sformatf("com_index %0d, expected %0d", idx, want.com_index));
                if (lvl !== want.com_level)
                    report($sformatf("com_level %0b, expected %0b", lvl, want.com_level));
            end
        endtask

        function int pending();
            return scan_q.size();
        endfunction
    endclass

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [1:0] i_action        = slmd_pkg::ACT_TICK;
    logic [6:0] i_value         = 7'd0;
    logic [1:0] i_battery_level = 2'd0;
    logic       i_blink_off     = 1'b0;
    logic       i_stall         = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_seg_drive;
    logic [1:0] o_com_index;
    logic       o_com_level;

    t_lcd_scoreboard sb = new();
    int              cycle_count = 0;
    int              stall_mode  = 0;
    int              stall_left  = 0;

    segment_lcd_mux_driver u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_value         (i_value),
        .i_battery_level (i_battery_level),
        .i_blink_off     (i_blink_off),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_seg_drive     (o_seg_drive),
        .o_com_index     (o_com_index),
        .o_com_level     (o_com_level)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(5, 40);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 99) < 30);
                default: i_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_seg_drive, o_com_index, o_com_level);
    end

    task send_item(logic [1:0] act, logic [6:0] val, logic [1:0] lvl, logic blink);
        i_valid         <= 1'b1;
        i_action        <= act;
        i_value         <= val;
        i_battery_level <= lvl;
        i_blink_off     <= blink;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(act, val, lvl, blink);
    endtask

    task send_ticks(int count);
        repeat (count) send_item(slmd_pkg::ACT_TICK, 7'($urandom_range(0, 127)),
                                 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int         counted;
        int         burst;
        int         gap;
        int         pick;
        bit         pressure_done;
        logic [1:0] act;
        logic [6:0] val;
        logic [1:0] lvl;
        logic       blink;

        counted       = 0;
        pressure_done = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_ticks(8);
        send_item(slmd_pkg::ACT_SET_MIN, 7'd127, 2'd3, 1'b0);
        send_item(slmd_pkg::ACT_SET_SEC, 7'd100, 2'd1, 1'b0);
        send_item(slmd_pkg::ACT_SET_MIN, 7'd88, 2'd0, 1'b1);
        send_item(ACT_UNUSED, 7'd55, 2'd2, 1'b0);
        send_ticks(4);
        send_item(slmd_pkg::ACT_SET_MIN, 7'd0, 2'd2, 1'b0);
        send_item(slmd_pkg::ACT_SET_SEC, 7'd0, 2'd0, 1'b0);
        send_ticks(2);
        send_item(slmd_pkg::ACT_SET_SEC, 7'd59, 2'd3, 1'b0);
        send_item(slmd_pkg::ACT_SET_MIN, 7'd9, 2'd0, 1'b0);
        send_ticks(4);
        i_valid <= 1'b0;
        wait_drained();

        while (counted < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                pick  = $urandom_range(0, 99);
                act   = (pick < 50) ? slmd_pkg::ACT_TICK :
                        (pick < 72) ? slmd_pkg::ACT_SET_MIN :
                        (pick < 94) ? slmd_pkg::ACT_SET_SEC : ACT_UNUSED;
                val   = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                    : 7'($urandom_range(0, 99));
                lvl   = 2'($urandom_range(0, 3));
                blink = ($urandom_range(0, 4) == 0);
                send_item(act, val, lvl, blink);
                counted++;
            end
            if (!pressure_done && counted >= RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                wait_drained();
                pressure_done = 1;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/slmd_pkg.sv
hw/rtl/slmd_pattern_upd.sv
hw/rtl/segment_lcd_mux_driver.sv
hw/rtl/slmd_checker.sv
dv/tb_top.sv
